### rtl/lobm_pkg.sv
// Shared types and constants for the order book matcher.
// Depends on nothing; imported by lobm_book and the top level.
`timescale 1ns / 1ps
package lobm_pkg;
  typedef enum logic [1:0] {
    ACT_BUY   = 2'd0,
    ACT_SELL  = 2'd1,
    ACT_BID   = 2'd2,
    ACT_OFFER = 2'd3
  } action_t;

  localparam int TOTAL_BITS  = 48;
  localparam int PROFIT_BITS = 32;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  localparam logic [PROFIT_BITS-1:0] PROFIT_MAX = {PROFIT_BITS{1'b1}};
endpackage

### rtl/lobm_book.sv
// One side of the book: price-time sorted entries held in registers.
// Depends on lobm_pkg; supports pop of the head, head size update, sorted insert.
`timescale 1ns / 1ps
module lobm_book #(
  parameter int BOOK_DEPTH = 16,
  parameter int PRICE_BITS = 16,
  parameter int SIZE_BITS  = 16,
  parameter bit IS_BID     = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop,
  input  logic                          upd,
  input  logic [SIZE_BITS-1:0]          upd_size,
  input  logic                          ins,
  input  logic [SIZE_BITS-1:0]          ins_size,
  input  logic [PRICE_BITS-1:0]         ins_price,
  input  logic                          ins_own,
  output logic [SIZE_BITS-1:0]          head_size,
  output logic [PRICE_BITS-1:0]         head_price,
  output logic                          head_own,
  output logic [$clog2(BOOK_DEPTH+1)-1:0] count
);
  import lobm_pkg::*;
  localparam int CW = $clog2(BOOK_DEPTH+1);

  logic [SIZE_BITS-1:0]  sz [BOOK_DEPTH];
  logic [PRICE_BITS-1:0] pr [BOOK_DEPTH];
  logic                  ow [BOOK_DEPTH];
  logic [BOOK_DEPTH-1:0] behind;

  assign head_size  = sz[0];
  assign head_price = pr[0];
  assign head_own   = ow[0];

  // entry i lies at or after the insert point
  always_comb begin
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (CW'(i) >= count) behind[i] = 1'b1;
      else if (IS_BID) behind[i] = pr[i] < ins_price;
      else behind[i] = pr[i] > ins_price;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < BOOK_DEPTH-1; i++) begin
        sz[i] <= sz[i+1]; pr[i] <= pr[i+1]; ow[i] <= ow[i+1];
      end
    end else if (upd) begin
      sz[0] <= upd_size;
    end else if (ins) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        if (behind[i]) begin
          if (i == 0 || !behind[(i == 0) ? 0 : i-1]) begin
            sz[i] <= ins_size; pr[i] <= ins_price; ow[i] <= ins_own;
          end else begin
            sz[i] <= sz[(i == 0) ? 0 : i-1];
            pr[i] <= pr[(i == 0) ? 0 : i-1];
            ow[i] <= ow[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (pop) begin
      count <= count - 1'b1;
    end else if (ins) begin
      count <= count + 1'b1;
    end
  end

  ap_pop: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop of empty book");
  ap_ins: assert property (@(posedge clk) disable iff (rst)
    ins |-> count < CW'(BOOK_DEPTH)) else $error("insert into full book");
  ap_one: assert property (@(posedge clk) disable iff (rst) !(pop && ins))
    else $error("pop and insert together");
endmodule

### rtl/lobm_mult.sv
// Shift-add multiplier shared by all fills; one bit of the size per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module lobm_mult #(
  parameter int A_BITS = 16,
  parameter int B_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     done,
  output logic [A_BITS+B_BITS-1:0] prod
);
  localparam int CW = $clog2(A_BITS+1);
  logic [A_BITS-1:0]        ar;
  logic [A_BITS+B_BITS-1:0] br;
  logic [CW-1:0]            cnt;
  logic                     busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ar   <= a;
        br   <= (A_BITS+B_BITS)'(b);
        prod <= '0;
        cnt  <= CW'(A_BITS);
      end else if (busy) begin
        if (ar[0]) prod <= prod + br;
        ar  <= ar >> 1;
        br  <= br << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/limit_order_book_matcher_core.sv
// Top level of the order book matcher: sequencer, two book sides, multiplier.
// Depends on lobm_pkg, lobm_book and lobm_mult.
//
//   channel | signals                                            | dir
//   order   | in_valid, in_stall, action, order_size, order_price | in
//   fill    | out_valid, out_stall, fill_size ... last            | out
//
// One order makes n fills (n up to BOOK_DEPTH); its final beat has last set.
// Each fill: check, shift-add multiply, accumulate, book update.
// Reset clears counts, total profit and the sequencer; book entries stay undefined.
// in_stall is high whenever the sequencer is not idle.
// out_stall holds the pending beat; the sequencer waits before it shows the next one.
`timescale 1ns / 1ps
module limit_order_book_matcher_core #(
  parameter int BOOK_DEPTH = 16,
  parameter int PRICE_BITS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lobm_pkg::action_t                action,
  input  logic [SIZE_BITS-1:0]             order_size,
  input  logic [PRICE_BITS-1:0]            order_price,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [SIZE_BITS-1:0]             fill_size,
  output logic [PRICE_BITS-1:0]            fill_price,
  output logic [lobm_pkg::PROFIT_BITS-1:0] fill_profit,
  output logic [lobm_pkg::TOTAL_BITS-1:0]  total_profit,
  output logic                             rested,
  output logic                             dropped,
  output logic                             last
);
  import lobm_pkg::*;
  localparam int CW = $clog2(BOOK_DEPTH+1);
  localparam int PW = SIZE_BITS + PRICE_BITS;
  localparam int XW = (PW > TOTAL_BITS) ? PW : TOTAL_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_ACC   = 6'b001000,
    S_OUT   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  logic                   is_bid, own;
  logic [SIZE_BITS-1:0]   rem, fill;
  logic [PRICE_BITS-1:0]  price, diff, st_price;
  logic [PROFIT_BITS-1:0] st_profit, profit_sat;
  logic [CW-1:0]          nfill;
  logic [TOTAL_BITS-1:0]  total, total_next;

  logic [SIZE_BITS-1:0]  b_hs, a_hs, o_hs;
  logic [PRICE_BITS-1:0] b_hp, a_hp, o_hp;
  logic                  b_ho, a_ho, o_ho;
  logic [CW-1:0]         b_cnt, a_cnt, o_cnt, m_cnt;
  logic b_pop, a_pop, b_upd, a_upd, b_ins, a_ins, pop, upd, ins;
  logic [SIZE_BITS-1:0]  upd_size;
  logic                  mstart, mdone;
  logic [PW-1:0]         prod;
  logic                  crosses, hit, out_free, emit;
  logic [PW-1:0]         psum;

  assign o_hs  = is_bid ? a_hs : b_hs;
  assign o_hp  = is_bid ? a_hp : b_hp;
  assign o_ho  = is_bid ? a_ho : b_ho;
  assign o_cnt = is_bid ? a_cnt : b_cnt;
  assign m_cnt = is_bid ? b_cnt : a_cnt;
  assign crosses = is_bid ? (price >= o_hp) : (price <= o_hp);
  assign hit = (rem != '0) && (o_cnt != '0) && (nfill < CW'(BOOK_DEPTH)) && crosses;
  assign out_free = !out_valid || !out_stall;
  assign pop = (state == S_OUT) && (o_hs == fill);
  assign upd = (state == S_OUT) && (o_hs != fill);
  assign upd_size = o_hs - fill;
  assign ins = (state == S_FIN) && out_free && (rem != '0) && (m_cnt < CW'(BOOK_DEPTH));
  assign emit = ((state == S_CHECK) && hit && (nfill != '0) && out_free)
             || ((state == S_FIN) && out_free);
  assign a_pop = pop && is_bid;
  assign b_pop = pop && !is_bid;
  assign a_upd = upd && is_bid;
  assign b_upd = upd && !is_bid;
  assign b_ins = ins && is_bid;
  assign a_ins = ins && !is_bid;
  assign in_stall = (state != S_IDLE);

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS),
              .SIZE_BITS(SIZE_BITS), .IS_BID(1'b1)) u_bid (
    .clk, .rst, .pop(b_pop), .upd(b_upd), .upd_size, .ins(b_ins),
    .ins_size(rem), .ins_price(price), .ins_own(own),
    .head_size(b_hs), .head_price(b_hp), .head_own(b_ho), .count(b_cnt));
  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS),
              .SIZE_BITS(SIZE_BITS), .IS_BID(1'b0)) u_ask (
    .clk, .rst, .pop(a_pop), .upd(a_upd), .upd_size, .ins(a_ins),
    .ins_size(rem), .ins_price(price), .ins_own(own),
    .head_size(a_hs), .head_price(a_hp), .head_own(a_ho), .count(a_cnt));
  lobm_mult #(.A_BITS(SIZE_BITS), .B_BITS(PRICE_BITS)) u_mul (
    .clk, .rst, .start(mstart), .a(fill), .b(diff), .done(mdone), .prod);

  always_comb begin
    psum = (own != o_ho) ? prod : '0;
    if (XW'(psum) > XW'(TOTAL_MAX - total)) total_next = TOTAL_MAX;
    else total_next = total + TOTAL_BITS'(psum);
    profit_sat = (XW'(psum) > XW'(PROFIT_MAX)) ? PROFIT_MAX : PROFIT_BITS'(psum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      mstart    <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      mstart    <= (state == S_CHECK) && hit && ((nfill == '0) || out_free);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_bid <= (action == ACT_BUY) || (action == ACT_BID);
            own    <= (action == ACT_BUY) || (action == ACT_SELL);
            rem    <= order_size;
            price  <= order_price;
            nfill  <= '0;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!hit) begin
            state <= S_FIN;
          end else if ((nfill == '0) || out_free) begin
            fill  <= (rem < o_hs) ? rem : o_hs;
            diff  <= (price >= o_hp) ? price - o_hp : o_hp - price;
            state <= S_MUL;
            if (nfill != '0) begin
              fill_size    <= fill;
              fill_price   <= st_price;
              fill_profit  <= st_profit;
              total_profit <= total;
              rested       <= 1'b0;
              dropped      <= 1'b0;
              last         <= 1'b0;
            end
          end
        end
        S_MUL: begin
          if (mdone) state <= S_ACC;
        end
        S_ACC: begin
          total     <= total_next;
          st_price  <= o_hp;
          st_profit <= profit_sat;
          state     <= S_OUT;
        end
        S_OUT: begin
          rem   <= rem - fill;
          nfill <= nfill + 1'b1;
          state <= S_CHECK;
        end
        S_FIN: begin
          if (out_free) begin
            if (nfill == '0) begin
              fill_size   <= '0;
              fill_price  <= '0;
              fill_profit <= '0;
            end else begin
              fill_size   <= fill;
              fill_price  <= st_price;
              fill_profit <= st_profit;
            end
            total_profit <= total;
            last    <= 1'b1;
            rested  <= (rem != '0) && (m_cnt < CW'(BOOK_DEPTH));
            dropped <= (rem != '0) && (m_cnt == CW'(BOOK_DEPTH));
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !in_stall) else $error("idle yet stalled");
  ap_tot: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_valid) |=> $stable(total)) else $error("total moved idle");
  ap_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rested) |-> (last && !dropped)) else $error("rested without last");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(total_profit) && $stable(last)))
    else $error("stalled beat changed");
endmodule
